// ===== sv/io_fixed_window_budget_core_defines.svh =====
// ----------------------------------------------------------------------------
// io_fixed_window_budget_core_defines.svh
// Assertion macros for the fixed-window budget block.
// ----------------------------------------------------------------------------
`ifndef IO_FIXED_WINDOW_BUDGET_CORE_DEFINES_SVH
`define IO_FIXED_WINDOW_BUDGET_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define IOFWB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iofwb assertion failed");
// next-cycle implication
`define IOFWB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iofwb assertion failed");
`else
`define IOFWB_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define IOFWB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/iofwb_pkg.sv =====
// ----------------------------------------------------------------------------
// iofwb_pkg
// Widths, codes and payload types shared by the budget block.
// ----------------------------------------------------------------------------
package iofwb_pkg;

   localparam int CNT_W   = 32;
   localparam int TIME_W  = 32;
   localparam int WIN_W   = 16;
   localparam int FUNC_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);

   // function codes
   localparam logic [FUNC_W-1:0] FN_CHK_BYTES  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_CHK_OPS    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_CHG_BYTES  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_CHG_OPS    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_RESTART    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_CHK_CHG_OP = 3'd5;
   localparam logic [FUNC_W-1:0] FN_RSVD6      = 3'd6;
   localparam logic [FUNC_W-1:0] FN_RSVD7      = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CNT_W-1:0]  amount;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic             allowed;
      logic [CNT_W-1:0] bytes_used_now;
      logic [CNT_W-1:0] ops_used_now;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] byte_limit;
      logic [CNT_W-1:0] op_limit;
      logic [WIN_W-1:0] window_length;
   } cfg_type;

endpackage

// ===== sv/io_fixed_window_budget_core.sv =====
// ----------------------------------------------------------------------------
// io_fixed_window_budget_core
// Fixed-window byte and operation budget for one requester.
//
// Requests enter on req_valid/req_ready as one word holding func, amount and
// now_time; each produces exactly one response word on rsp_valid/rsp_ready
// with the pass flag and both used counters after the request.
// Limits and window length are written through csr_wr_en/csr_index/csr_wdata;
// the user must write only while no request is in flight and send a restart
// after a change; the block enforces neither. A held word enters the result
// register once it is free (one input register, one result register, logic
// in between). Throughput: one request per cycle unless rsp_ready stalls; the
// window counters update in the same cycle the result register loads, so
// back-to-back requests see the state left by the one before.
// Reset clears both counters and the window start, zeroes both limits
// (unlimited) and sets the window length to 1000.
// When rsp_ready is low the result word holds and the input register keeps
// one more request; req_ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "io_fixed_window_budget_core_defines.svh"

module io_fixed_window_budget_core import iofwb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    req_accept;
   cfg_type cfg;
   rsp_type result;

   iofwb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   iofwb_budget u_budget (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // move the held request into the result register when it is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IOFWB_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, rsp_valid_ff)
   `IOFWB_ASSERT_NOW(a_ready_when_rsp_empty, clock, reset, !rsp_valid_ff, req_ready)
   `IOFWB_ASSERT_NEXT(a_restart_clears, clock, reset,
      advance && (in_data_ff.func == FN_RESTART),
      rsp_data_ff.allowed && (rsp_data_ff.bytes_used_now == '0) &&
      (rsp_data_ff.ops_used_now == '0))
   `IOFWB_ASSERT_NEXT(a_reserved_denied, clock, reset,
      advance && ((in_data_ff.func == FN_RSVD6) || (in_data_ff.func == FN_RSVD7)),
      !rsp_data_ff.allowed)

endmodule

// ===== sv/iofwb_csr.sv =====
// ----------------------------------------------------------------------------
// iofwb_csr
// Limit and window-length registers behind the plain write port.
// ----------------------------------------------------------------------------
module iofwb_csr import iofwb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTE_LIMIT: cfg_in.byte_limit    = csr_wdata[CNT_W-1:0];
            CSR_OP_LIMIT:   cfg_in.op_limit      = csr_wdata[CNT_W-1:0];
            CSR_WINDOW_LEN: cfg_in.window_length = csr_wdata[WIN_W-1:0];
            default: begin
               // unmapped index: drop the write
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_limit    <= '0;
         cfg_ff.op_limit      <= '0;
         cfg_ff.window_length <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/iofwb_budget.sv =====
// ----------------------------------------------------------------------------
// iofwb_budget
// Window state and the single-pass check / charge / restart logic.
// ----------------------------------------------------------------------------
module iofwb_budget import iofwb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type cmd,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [CNT_W-1:0] ONE_OP = CNT_W'(1);

   logic [CNT_W-1:0]  bytes_used_ff, bytes_used_in;
   logic [CNT_W-1:0]  ops_used_ff, ops_used_in;
   logic [TIME_W-1:0] window_start_ff, window_start_in;
   logic [TIME_W-1:0] elapsed;
   logic              expired;
   logic              allowed;

   function automatic logic fits(input logic [CNT_W-1:0] lim,
                                 input logic [CNT_W-1:0] used,
                                 input logic [CNT_W-1:0] amt);
      return (amt <= lim) && (used <= lim - amt);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   // elapsed time wraps with the time width
   assign elapsed = cmd.now_time - window_start_ff;
   assign expired = elapsed >= {{(TIME_W-WIN_W){1'b0}}, cfg.window_length};

   always_comb begin
      bytes_used_in   = bytes_used_ff;
      ops_used_in     = ops_used_ff;
      window_start_in = window_start_ff;
      allowed         = 1'b1;
      unique case (cmd.func)
         FN_CHK_BYTES: begin
            if (cfg.byte_limit != '0) begin
               if (expired) begin
                  bytes_used_in   = '0;
                  ops_used_in     = '0;
                  window_start_in = cmd.now_time;
               end
               allowed = fits(cfg.byte_limit, bytes_used_in, cmd.amount);
            end
         end
         FN_CHK_OPS: begin
            if (cfg.op_limit != '0) begin
               if (expired) begin
                  bytes_used_in   = '0;
                  ops_used_in     = '0;
                  window_start_in = cmd.now_time;
               end
               allowed = fits(cfg.op_limit, ops_used_in, cmd.amount);
            end
         end
         FN_CHG_BYTES: begin
            if (cfg.byte_limit != '0) begin
               bytes_used_in = sat_add(bytes_used_ff, cmd.amount);
            end
         end
         FN_CHG_OPS: begin
            if (cfg.op_limit != '0) begin
               ops_used_in = sat_add(ops_used_ff, cmd.amount);
            end
         end
         FN_RESTART: begin
            bytes_used_in   = '0;
            ops_used_in     = '0;
            window_start_in = cmd.now_time;
         end
         FN_CHK_CHG_OP: begin
            if (cfg.op_limit != '0) begin
               if (expired) begin
                  bytes_used_in   = '0;
                  ops_used_in     = '0;
                  window_start_in = cmd.now_time;
               end
               allowed = fits(cfg.op_limit, ops_used_in, ONE_OP);
               // charge one op only on a pass
               if (allowed) begin
                  ops_used_in = sat_add(ops_used_in, ONE_OP);
               end
            end
         end
         default: begin
            allowed = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_used_ff   <= '0;
         ops_used_ff     <= '0;
         window_start_ff <= '0;
      end else if (step) begin
         bytes_used_ff   <= bytes_used_in;
         ops_used_ff     <= ops_used_in;
         window_start_ff <= window_start_in;
      end
   end

   assign result.allowed        = allowed;
   assign result.bytes_used_now = bytes_used_in;
   assign result.ops_used_now   = ops_used_in;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-window byte and operation budget.
// Requests go in through a queue-fed driver, a clocked monitor compares
// every response word against a cycle-free model of the window counters,
// and limits are rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module testbench import iofwb_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_WORDS = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BYTE_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model of the budget registers and counters
   logic [CNT_W-1:0]  byte_limit = '0;
   logic [CNT_W-1:0]  op_limit = '0;
   logic [WIN_W-1:0]  win_len = WINDOW_RESET;
   logic [CNT_W-1:0]  bytes_used = '0;
   logic [CNT_W-1:0]  ops_used = '0;
   logic [TIME_W-1:0] win_start = '0;

   req_type pending_requests[$];
   rsp_type predicted_responses[$];
   rsp_type next_response;

   logic [TIME_W-1:0] wall_ms = '0;
   logic idling_on = 1'b1;
   int send_gap = 0;
   int recv_stall = 0;
   int error_count = 0;
   int cycle_count = 0;

   io_fixed_window_budget_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void restart_window(logic [TIME_W-1:0] stamp);
      bytes_used = '0;
      ops_used = '0;
      win_start = stamp;
   endfunction

   function automatic logic [CNT_W-1:0] saturating_add(logic [CNT_W-1:0] used,
                                                      logic [CNT_W-1:0] amt);
      logic [CNT_W:0] sum;
      sum = {1'b0, used} + {1'b0, amt};
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   endfunction

   // restart on an expired window, then test against the limit without wrap
   function automatic logic window_check(logic [CNT_W-1:0] limit, logic on_ops,
                                         logic [CNT_W-1:0] amt,
                                         logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] elapsed;
      logic [CNT_W-1:0] used;
      if (limit == '0) return 1'b1;
      elapsed = stamp - win_start;
      if (elapsed >= TIME_W'(win_len)) restart_window(stamp);
      used = on_ops ? ops_used : bytes_used;
      if (amt > limit) return 1'b0;
      return used <= limit - amt;
   endfunction

   function automatic rsp_type predict_budget(req_type word);
      rsp_type res;
      logic ok;
      ok = 1'b1;
      case (word.func)
         FN_CHK_BYTES: begin
            ok = window_check(byte_limit, 1'b0, word.amount, word.now_time);
         end
         FN_CHK_OPS: begin
            ok = window_check(op_limit, 1'b1, word.amount, word.now_time);
         end
         FN_CHG_BYTES: begin
            if (byte_limit != '0) bytes_used = saturating_add(bytes_used, word.amount);
         end
         FN_CHG_OPS: begin
            if (op_limit != '0) ops_used = saturating_add(ops_used, word.amount);
         end
         FN_RESTART: begin
            restart_window(word.now_time);
         end
         FN_CHK_CHG_OP: begin
            ok = window_check(op_limit, 1'b1, CNT_W'(1), word.now_time);
            if (ok && op_limit != '0) ops_used = saturating_add(ops_used, CNT_W'(1));
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      res.allowed = ok;
      res.bytes_used_now = bytes_used;
      res.ops_used_now = ops_used;
      return res;
   endfunction

   // driver: hold a word until taken, then advance to the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_responses.push_back(predict_budget(req_data));
            void'(pending_requests.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_requests.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_requests[0];
               if (idling_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               $error("unexpected response word");
               error_count++;
            end else begin
               next_response = predicted_responses.pop_front();
               if (rsp_data.allowed !== next_response.allowed) begin
                  $error("allowed: expected %0d, got %0d",
                         next_response.allowed, rsp_data.allowed);
                  error_count++;
               end
               if (rsp_data.bytes_used_now !== next_response.bytes_used_now) begin
                  $error("bytes_used_now: expected %0h, got %0h",
                         next_response.bytes_used_now, rsp_data.bytes_used_now);
                  error_count++;
               end
               if (rsp_data.ops_used_now !== next_response.ops_used_now) begin
                  $error("ops_used_now: expected %0h, got %0h",
                         next_response.ops_used_now, rsp_data.ops_used_now);
                  error_count++;
               end
            end
         end
         if (recv_stall != 0) begin
            rsp_ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 12);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic push_word(logic [FUNC_W-1:0] func, logic [CNT_W-1:0] amt,
                            logic [TIME_W-1:0] stamp);
      req_type word;
      word.func = func;
      word.amount = amt;
      word.now_time = stamp;
      pending_requests.push_back(word);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || predicted_responses.size() != 0 || req_valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BYTE_LIMIT: byte_limit = val[CNT_W-1:0];
         CSR_OP_LIMIT:   op_limit = val[CNT_W-1:0];
         CSR_WINDOW_LEN: win_len = val[WIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drain, rewrite all limits, and leave off at a falling edge for loading
   task automatic set_budget(logic [CNT_W-1:0] blim, logic [CNT_W-1:0] olim,
                             logic [CSR_DATA_W-1:0] wlen_word);
      wait_drained();
      write_csr(CSR_BYTE_LIMIT, blim);
      write_csr(CSR_OP_LIMIT, olim);
      write_csr(CSR_WINDOW_LEN, wlen_word);
      @(negedge clock);
   endtask

   function automatic logic [CNT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(1, 200);
      endcase
   endfunction

   // mostly amounts that fit a few times per window; now and then huge ones
   function automatic logic [CNT_W-1:0] budget_amount(logic [CNT_W-1:0] limit);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return '1;
         default: begin
            if (limit == '0) return $urandom_range(0, 1000);
            return $urandom_range(0, (limit >> 2) + 1);
         end
      endcase
   endfunction

   task automatic run_random_phase(int count);
      logic [CNT_W-1:0] blim;
      logic [CNT_W-1:0] olim;
      logic [CNT_W-1:0] amt;
      logic [WIN_W-1:0] wlen;
      int n;
      int pick;
      blim = pick_limit();
      olim = pick_limit();
      case ($urandom_range(0, 4))
         0: wlen = 16'd1;
         1: wlen = 16'hFFFF;
         2: wlen = WIN_W'($urandom);
         default: wlen = WIN_W'($urandom_range(2, 60));
      endcase
      set_budget(blim, olim, {16'($urandom), wlen});
      push_word(FN_RESTART, $urandom, wall_ms);
      n = 1;
      while (n < count) begin
         case ($urandom_range(0, 49))
            0: wall_ms = $urandom;
            1: wall_ms = wall_ms + TIME_W'(wlen);
            2: wall_ms = wall_ms + TIME_W'(wlen) - 1;
            default: wall_ms = wall_ms + $urandom_range(0, wlen / 8 + 1);
         endcase
         pick = $urandom_range(0, 19);
         if (pick < 7) begin
            amt = budget_amount(blim);
            push_word(FN_CHK_BYTES, amt, wall_ms);
            push_word(FN_CHG_BYTES, amt, wall_ms);
            n += 2;
         end else if (pick < 11) begin
            push_word(FN_CHK_CHG_OP, $urandom, wall_ms);
            n++;
         end else if (pick < 14) begin
            amt = budget_amount(olim);
            push_word(FN_CHK_OPS, amt, wall_ms);
            push_word(FN_CHG_OPS, amt, wall_ms);
            n += 2;
         end else if (pick == 14) begin
            push_word(FN_RESTART, $urandom, wall_ms);
            n++;
         end else if (pick < 17) begin
            push_word(FUNC_W'($urandom_range(0, 3)), budget_amount(blim), wall_ms);
            n++;
         end else begin
            // noise: any code, any amount, any time
            push_word(FUNC_W'($urandom), $urandom, $urandom);
            n++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset limits are unlimited: every code once, field extremes
      push_word(FN_CHK_BYTES, '1, '0);
      push_word(FN_CHK_OPS, '0, '1);
      push_word(FN_CHG_BYTES, '1, '0);
      push_word(FN_CHG_OPS, '1, '1);
      push_word(FN_RESTART, '0, 32'h0000_0100);
      push_word(FN_CHK_CHG_OP, '1, '1);
      push_word(FN_RSVD6, '1, '1);
      push_word(FN_RSVD7, '0, '0);

      // small limits: fill, overflow the request, expire the window
      set_budget(32'd100, 32'd3, 32'd10);
      push_word(FN_RESTART, '0, 32'd0);
      push_word(FN_CHK_BYTES, 32'd100, 32'd1);
      push_word(FN_CHG_BYTES, 32'd60, 32'd1);
      push_word(FN_CHK_BYTES, 32'd41, 32'd2);
      push_word(FN_CHK_BYTES, 32'd40, 32'd2);
      push_word(FN_CHK_BYTES, '1, 32'd3);
      repeat (4) push_word(FN_CHK_CHG_OP, '0, 32'd4);
      push_word(FN_CHK_OPS, '0, 32'd10);
      push_word(FN_CHG_OPS, '1, 32'd10);

      // full-scale limits: saturate both counters, wrap the time
      set_budget('1, '1, 32'h5A5A_FFFF);
      push_word(FN_RESTART, '0, 32'hFFFF_FFF0);
      push_word(FN_CHG_BYTES, '1, 32'hFFFF_FFF0);
      push_word(FN_CHG_BYTES, 32'd1, 32'hFFFF_FFF1);
      push_word(FN_CHK_BYTES, '0, 32'h0000_0010);
      push_word(FN_CHG_OPS, 32'hFFFF_FFFE, 32'h0000_0010);
      push_word(FN_CHK_CHG_OP, '0, 32'h0000_0011);

      // zero window: every limited check restarts
      set_budget(32'd5, '0, 32'hA5A5_0000);
      push_word(FN_CHK_BYTES, 32'd5, 32'd123);
      push_word(FN_CHG_BYTES, 32'd5, 32'd123);
      push_word(FN_CHK_BYTES, 32'd1, 32'd123);
      push_word(FN_CHK_CHG_OP, '0, 32'd123);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1) begin
            wait_drained();
            idling_on = 1'b0;
         end
         run_random_phase(PHASE_WORDS);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (predicted_responses.size() != 0) begin
         $error("%0d response words never arrived", predicted_responses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
